@@ rtl/mcaws_pkg.sv @@
// Shared types and constants for the multicast ack window sender.
// No dependencies; used by every module under rtl/ except mcaws_ram.
package mcaws_pkg;

  localparam int IdW   = 16;
  localparam int OwedW = 8;

  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_ACK  = 2'd1;
  localparam logic [1:0] MODE_NAK  = 2'd2;
  localparam logic [1:0] MODE_TICK = 2'd3;

  localparam logic [2:0] KIND_TRANSMIT = 3'd0;
  localparam logic [2:0] KIND_ACKREQ   = 3'd1;
  localparam logic [2:0] KIND_RELEASE  = 3'd2;
  localparam logic [2:0] KIND_FULL     = 3'd3;
  localparam logic [2:0] KIND_NONE     = 3'd4;

  localparam logic [1:0] CFG_REQ_RCV  = 2'd0;
  localparam logic [1:0] CFG_WIN_LIM  = 2'd1;
  localparam logic [1:0] CFG_ACK_TMO  = 2'd2;
  localparam logic [1:0] CFG_NAK_HOLD = 2'd3;

  typedef struct packed {
    logic [1:0]     mode;
    logic [IdW-1:0] seq_id;
    logic [2:0]     receiver;
  } in_t;

  typedef struct packed {
    logic [2:0]     kind;
    logic [IdW-1:0] out_id;
    logic [3:0]     pending;
    logic           last;
  } out_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [OwedW-1:0] owed;
  } slot_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ENQ,
    OP_TICK,
    OP_PUSH_ACKREQ,
    OP_SRCH_INIT,
    OP_SRCH_MISS,
    OP_FOUND,
    OP_ACK_INIT,
    OP_ACK_STEP,
    OP_NAK_ARM,
    OP_NAK_STEP,
    OP_PUSH_NONE,
    OP_FLUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic can_push;
    logic out_free;
    logic tick_req;
    logic k_end;
    logic match;
    logic found;
    logic hold;
    logic ack_cont;
    logic any;
    logic is_ack;
  } dp_stat_t;

endpackage

@@ rtl/mcaws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcaws_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mcaws_dp.sv @@
// Datapath: config registers, slot ring RAM, pointers, timers, result staging.
// Depends on mcaws_pkg and mcaws_ram.
module mcaws_dp #(
  parameter int WINDOW_SLOTS  = 16,
  parameter int NUM_RECEIVERS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mcaws_pkg::in_t     in_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata,
  input  mcaws_pkg::dp_cmd_t cmd,
  output mcaws_pkg::dp_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output mcaws_pkg::out_t    out_data
);

  localparam int PW = $clog2(WINDOW_SLOTS);
  localparam logic [PW-1:0] LastSlot = PW'(WINDOW_SLOTS - 1);

  logic [7:0]  req_r;
  logic [3:0]  lim_r;
  logic [15:0] ato_r, nho_r;

  logic [PW-1:0] oldest_r, nfree_r, wp_r;
  logic [3:0]    held_r, k_r, pos_r, hs_r;
  logic          found_r, rel_r, any_r;
  logic [15:0]   sil_r, lnak_r, ntmr_r;
  logic [1:0]    mode_r;
  logic [15:0]   id_r;
  logic [2:0]    rcv_r;

  logic             stg_v_r, out_v_r;
  mcaws_pkg::out_t  stg_r, out_r;
  logic             stg_v_nxt, out_v_nxt;
  mcaws_pkg::out_t  stg_nxt, out_nxt;

  logic             ram_we;
  logic [PW-1:0]    ram_waddr;
  mcaws_pkg::slot_t ram_wdata, ram_rdata;

  mcaws_ram #(.WIDTH($bits(mcaws_pkg::slot_t)), .DEPTH(WINDOW_SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (wp_r),
    .rdata (ram_rdata)
  );

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == LastSlot) ? '0 : p + PW'(1);
  endfunction

  logic [7:0]  rcv_mask;
  logic [7:0]  clr;
  logic [6:0]  lim_eff;
  logic        full;
  logic [15:0] sil_inc;
  logic [PW-1:0] newest;
  logic        in_pos;
  logic [7:0]  owed_new;
  logic        out_free, can_push;
  logic        push;
  mcaws_pkg::out_t push_res;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      rcv_mask[i] = (i < NUM_RECEIVERS);
    end
  end

  assign clr      = ({29'd0, rcv_r} < NUM_RECEIVERS) ? (8'd1 << rcv_r) : 8'd0;
  assign lim_eff  = ({3'd0, lim_r} < 7'(WINDOW_SLOTS)) ? {3'd0, lim_r} : 7'(WINDOW_SLOTS);
  assign full     = {3'd0, held_r} >= lim_eff;
  assign sil_inc  = (sil_r == 16'hFFFF) ? sil_r : sil_r + 16'd1;
  assign newest   = (nfree_r == '0) ? LastSlot : nfree_r - PW'(1);
  assign in_pos   = found_r && (k_r <= pos_r);
  assign owed_new = in_pos ? (ram_rdata.owed & ~clr) : ram_rdata.owed;
  assign out_free = !out_v_r || !out_stall;
  assign can_push = !stg_v_r || out_free;

  always_comb begin
    stat.can_push = can_push;
    stat.out_free = out_free;
    stat.tick_req = (held_r != 4'd0) && (sil_inc >= ato_r);
    stat.k_end    = (k_r == held_r);
    stat.match    = (ram_rdata.id == id_r);
    stat.found    = found_r;
    stat.hold     = (id_r == lnak_r) && (ntmr_r < nho_r);
    stat.ack_cont = (k_r < hs_r) && (in_pos || rel_r);
    stat.any      = any_r;
    stat.is_ack   = (mode_r == mcaws_pkg::MODE_ACK);
  end

  // Result produced by this cycle's command, and slot write-back
  always_comb begin
    push      = 1'b0;
    push_res  = '{kind: mcaws_pkg::KIND_NONE, out_id: '0, pending: held_r, last: 1'b0};
    ram_we    = 1'b0;
    ram_waddr = nfree_r;
    ram_wdata = '{id: id_r, owed: req_r & rcv_mask};
    case (cmd.op)
      mcaws_pkg::OP_ENQ: begin
        push = 1'b1;
        push_res.out_id = id_r;
        if (full) begin
          push_res.kind = mcaws_pkg::KIND_FULL;
        end else begin
          push_res.kind    = mcaws_pkg::KIND_TRANSMIT;
          push_res.pending = held_r + 4'd1;
          ram_we           = 1'b1;
        end
      end
      mcaws_pkg::OP_TICK: begin
        push = !stat.tick_req;
      end
      mcaws_pkg::OP_PUSH_ACKREQ: begin
        push = 1'b1;
        push_res.kind   = mcaws_pkg::KIND_ACKREQ;
        push_res.out_id = ram_rdata.id;
      end
      mcaws_pkg::OP_ACK_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = wp_r;
        ram_wdata = '{id: ram_rdata.id, owed: owed_new};
        if (rel_r && owed_new == 8'd0) begin
          push = 1'b1;
          push_res.kind    = mcaws_pkg::KIND_RELEASE;
          push_res.out_id  = ram_rdata.id;
          push_res.pending = held_r - 4'd1;
        end
      end
      mcaws_pkg::OP_NAK_STEP: begin
        push = 1'b1;
        push_res.kind   = mcaws_pkg::KIND_TRANSMIT;
        push_res.out_id = ram_rdata.id;
      end
      mcaws_pkg::OP_PUSH_NONE: begin
        push = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register / staging: staging holds back one result so the
  // final one can be tagged last
  always_comb begin
    stg_v_nxt = stg_v_r;
    stg_nxt   = stg_r;
    out_v_nxt = out_v_r && !out_free;
    out_nxt   = out_r;
    if (push) begin
      stg_v_nxt = 1'b1;
      stg_nxt   = push_res;
      if (stg_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = stg_r;
      end
    end else if (cmd.op == mcaws_pkg::OP_FLUSH) begin
      stg_v_nxt    = 1'b0;
      out_v_nxt    = 1'b1;
      out_nxt      = stg_r;
      out_nxt.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r    <= 8'd0;
      lim_r    <= 4'd15;
      ato_r    <= 16'd10;
      nho_r    <= 16'd20;
      oldest_r <= '0;
      nfree_r  <= '0;
      wp_r     <= '0;
      held_r   <= 4'd0;
      k_r      <= 4'd0;
      pos_r    <= 4'd0;
      hs_r     <= 4'd0;
      found_r  <= 1'b0;
      rel_r    <= 1'b0;
      any_r    <= 1'b0;
      sil_r    <= 16'd0;
      lnak_r   <= 16'd0;
      ntmr_r   <= 16'hFFFF;
      mode_r   <= mcaws_pkg::MODE_ENQ;
      stg_v_r  <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          mcaws_pkg::CFG_REQ_RCV:  req_r <= cfg_wdata[7:0];
          mcaws_pkg::CFG_WIN_LIM:  lim_r <= cfg_wdata[3:0];
          mcaws_pkg::CFG_ACK_TMO:  ato_r <= cfg_wdata;
          mcaws_pkg::CFG_NAK_HOLD: nho_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      stg_v_r <= stg_v_nxt;
      stg_r   <= stg_nxt;
      out_v_r <= out_v_nxt;
      out_r   <= out_nxt;
      if (push) begin
        any_r <= 1'b1;
      end

      case (cmd.op)
        mcaws_pkg::OP_LOAD: begin
          mode_r <= in_data.mode;
          id_r   <= in_data.seq_id;
          rcv_r  <= in_data.receiver;
          any_r  <= 1'b0;
        end
        mcaws_pkg::OP_ENQ: begin
          if (!full) begin
            if (held_r == 4'd0) begin
              sil_r <= 16'd0;
            end
            nfree_r <= wrap_inc(nfree_r);
            held_r  <= held_r + 4'd1;
          end
        end
        mcaws_pkg::OP_TICK: begin
          if (ntmr_r != 16'hFFFF) begin
            ntmr_r <= ntmr_r + 16'd1;
          end
          if (held_r == 4'd0 || stat.tick_req) begin
            sil_r <= 16'd0;
          end else begin
            sil_r <= sil_inc;
          end
          wp_r <= newest;
        end
        mcaws_pkg::OP_SRCH_INIT: begin
          sil_r   <= 16'd0;
          k_r     <= 4'd0;
          wp_r    <= oldest_r;
          found_r <= 1'b0;
        end
        mcaws_pkg::OP_SRCH_MISS: begin
          k_r  <= k_r + 4'd1;
          wp_r <= wrap_inc(wp_r);
        end
        mcaws_pkg::OP_FOUND: begin
          found_r <= 1'b1;
          pos_r   <= k_r;
        end
        mcaws_pkg::OP_ACK_INIT: begin
          k_r   <= 4'd0;
          wp_r  <= oldest_r;
          rel_r <= 1'b1;
          hs_r  <= held_r;
        end
        mcaws_pkg::OP_ACK_STEP: begin
          if (rel_r && owed_new == 8'd0) begin
            oldest_r <= wrap_inc(oldest_r);
            held_r   <= held_r - 4'd1;
          end else begin
            rel_r <= 1'b0;
          end
          k_r  <= k_r + 4'd1;
          wp_r <= wrap_inc(wp_r);
        end
        mcaws_pkg::OP_NAK_ARM: begin
          lnak_r <= id_r;
          ntmr_r <= 16'd0;
        end
        mcaws_pkg::OP_NAK_STEP: begin
          k_r  <= k_r + 4'd1;
          wp_r <= wrap_inc(wp_r);
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("result pushed with staging and output both full");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {3'd0, held_r} <= 7'(WINDOW_SLOTS))
    else $error("held count exceeds ring depth");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == mcaws_pkg::OP_FLUSH |=> !stg_v_r && out_v_r && out_r.last)
    else $error("flush did not move the final result out");

endmodule

@@ rtl/mcaws_ctrl.sv @@
// Controller: sequences result steps, and for ack/nak search and walk steps.
// Depends on mcaws_pkg; drives mcaws_dp through a command struct.
module mcaws_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_mode,
  output logic                in_stall,
  input  mcaws_pkg::dp_stat_t stat,
  output mcaws_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ENQ, S_TICK, S_TICK_RD, S_TICK_USE, S_SINIT, S_S_RD, S_S_CHK,
    S_POST, S_A_RD, S_A_USE, S_N_RD, S_N_USE, S_NONE, S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = mcaws_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = mcaws_pkg::OP_LOAD;
          case (in_mode)
            mcaws_pkg::MODE_ENQ:  state_nxt = S_ENQ;
            mcaws_pkg::MODE_TICK: state_nxt = S_TICK;
            default:              state_nxt = S_SINIT;
          endcase
        end
      end
      S_ENQ: begin
        if (stat.can_push) begin
          cmd.op    = mcaws_pkg::OP_ENQ;
          state_nxt = S_FLUSH;
        end
      end
      S_TICK: begin
        if (stat.can_push) begin
          cmd.op    = mcaws_pkg::OP_TICK;
          state_nxt = stat.tick_req ? S_TICK_RD : S_FLUSH;
        end
      end
      S_TICK_RD: state_nxt = S_TICK_USE;
      S_TICK_USE: begin
        if (stat.can_push) begin
          cmd.op    = mcaws_pkg::OP_PUSH_ACKREQ;
          state_nxt = S_FLUSH;
        end
      end
      S_SINIT: begin
        cmd.op    = mcaws_pkg::OP_SRCH_INIT;
        state_nxt = S_S_RD;
      end
      S_S_RD: state_nxt = stat.k_end ? S_POST : S_S_CHK;
      S_S_CHK: begin
        if (stat.match) begin
          cmd.op    = mcaws_pkg::OP_FOUND;
          state_nxt = S_POST;
        end else begin
          cmd.op    = mcaws_pkg::OP_SRCH_MISS;
          state_nxt = S_S_RD;
        end
      end
      S_POST: begin
        if (stat.is_ack) begin
          cmd.op    = mcaws_pkg::OP_ACK_INIT;
          state_nxt = S_A_RD;
        end else if (!stat.found || stat.hold) begin
          state_nxt = S_NONE;
        end else begin
          cmd.op    = mcaws_pkg::OP_NAK_ARM;
          state_nxt = S_N_RD;
        end
      end
      S_A_RD: begin
        if (stat.ack_cont) begin
          state_nxt = S_A_USE;
        end else begin
          state_nxt = stat.any ? S_FLUSH : S_NONE;
        end
      end
      S_A_USE: begin
        if (stat.can_push) begin
          cmd.op    = mcaws_pkg::OP_ACK_STEP;
          state_nxt = S_A_RD;
        end
      end
      S_N_RD: state_nxt = stat.k_end ? S_FLUSH : S_N_USE;
      S_N_USE: begin
        if (stat.can_push) begin
          cmd.op    = mcaws_pkg::OP_NAK_STEP;
          state_nxt = S_N_RD;
        end
      end
      S_NONE: begin
        if (stat.can_push) begin
          cmd.op    = mcaws_pkg::OP_PUSH_NONE;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.op    = mcaws_pkg::OP_FLUSH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == mcaws_pkg::OP_LOAD |-> state_r == S_IDLE && in_valid)
    else $error("request loaded outside idle");

  a_flush_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == mcaws_pkg::OP_FLUSH |=> state_r == S_IDLE)
    else $error("flush did not end the request");

  a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == mcaws_pkg::OP_ACK_STEP || cmd.op == mcaws_pkg::OP_NAK_STEP)
      |-> stat.can_push)
    else $error("walk step issued without result room");

endmodule

@@ rtl/multicast_ack_window_sender.sv @@
// Transmit window of a reliable multicast sender.
// Requests enter on in_valid/in_stall as in_data (mode, seq_id, receiver):
// enqueue, ack, nak or tick. Results leave on out_valid/out_stall as
// out_data (kind, out_id, pending, last); last marks the final result of a
// request. Each request yields 1 to 15 results.
// Registers are written on cfg_we with cfg_idx/cfg_wdata; the user must
// write them only while idle, as the block does not enforce it. One
// request at a time; in_stall is high from acceptance until its last
// result is in the output register. Ack and nak requests search the
// window and then walk it slot by slot, each slot taking a read step and
// a use step, as the slot RAM has a single registered read port.
// One result is staged behind the output register so the last one can be
// tagged; out_stall holds the output and the sequencer waits for room.
// Reset (rst_n low, synchronous) empties the window, restores register
// defaults and drops any result in flight; slot RAM contents need no clear.
// Depends on mcaws_pkg, mcaws_ctrl, mcaws_dp, mcaws_ram.
module multicast_ack_window_sender #(
  parameter int WINDOW_SLOTS  = 16,
  parameter int NUM_RECEIVERS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  mcaws_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output mcaws_pkg::out_t out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [15:0]     cfg_wdata
);

  mcaws_pkg::dp_cmd_t  cmd;
  mcaws_pkg::dp_stat_t stat;

  mcaws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mcaws_dp #(
    .WINDOW_SLOTS  (WINDOW_SLOTS),
    .NUM_RECEIVERS (NUM_RECEIVERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
